[hdl/wind_speed_pulse_meter_core_assert.svh]
// Assertion macros for the wind speed pulse meter
`ifndef WIND_SPEED_PULSE_METER_CORE_ASSERT_SVH
`define WIND_SPEED_PULSE_METER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WSPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WSPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wspm_pkg.sv]
`timescale 1ns / 1ps

package wspm_pkg;

    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 14;
    localparam int REP_COUNT_W = 16;
    localparam int FUNC_W      = 2;

    // divider geometry: 84480 needs 17 bits, divisors are up to 32 bits
    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_STEP_W = $clog2(DIVIDEND_W);

    localparam logic [TIME_W-1:0]     MIN_PULSE_MS  = 32'd5;
    localparam logic [TIME_W-1:0]     TIMEOUT_RESET = 32'd5000;
    localparam logic [DIVIDEND_W-1:0] SPEED_NUM     = 17'd84480;
    localparam logic [SPEED_W-1:0]    SPEED_MAX     = 14'd14080;

    localparam logic [FUNC_W-1:0] FUNC_PULSE      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MEAN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hdl/wspm_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module wspm_div
    import wspm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;

    logic [DIVISOR_W:0] rem_shift;
    logic [DIVISOR_W:0] rem_sub;
    logic               fits;

    assign rem_shift = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (div_req.start) begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(DIVIDEND_W - 1);
            dvd_next  = div_req.dividend;
            dsr_next  = div_req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // quotient bits shift in behind the dividend
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = dvd_reg;

endmodule

[hdl/wind_speed_pulse_meter_core.sv]
`timescale 1ns / 1ps
// Path: read-clear, idle selector and pulses 5 ms or closer go from ST_EVAL to ST_DONE;
// longer pulses pass the 17-step divider, update ticks ST_MEAN and then the divider.
// Throughput: one item at a time; the next item is taken the cycle after the result
// is loaded into the output register, which holds it until m_tready.
// Reset (aresetn, synchronous, active low): speed, mean, count and last pulse time
// cleared, timeout_ms back to 5000, no result pending.

`include "wind_speed_pulse_meter_core_assert.svh"

module wind_speed_pulse_meter_core
    import wspm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,     // now_ms
    input  logic [FUNC_W-1:0] s_tuser,     // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,     // speed_now, speed_mean, mean_count, zero pad
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data  // timeout_ms
);

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [TIME_W-1:0]      last_pulse_reg, last_pulse_next;
    logic [TIME_W-1:0]      timeout_reg, timeout_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [SPEED_W-1:0]     mean_reg, mean_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SPEED_W-1:0]     out_speed_reg, out_speed_next;
    logic [SPEED_W-1:0]     out_mean_reg, out_mean_next;
    logic [REP_COUNT_W-1:0] out_count_reg, out_count_next;

    logic [TIME_W-1:0]  elapsed;
    logic               diff_neg;
    logic [SPEED_W-1:0] diff_mag;
    logic [SPEED_W-1:0] quot;

    div_req_t div_req;
    div_rsp_t div_rsp;

    wspm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign elapsed  = now_reg - last_pulse_reg;   // wraps mod 2^32
    assign diff_neg = mean_reg > speed_reg;
    assign diff_mag = diff_neg ? (mean_reg - speed_reg) : (speed_reg - mean_reg);
    assign quot     = div_rsp.quotient[SPEED_W-1:0];

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        now_next        = now_reg;
        last_pulse_next = last_pulse_reg;
        timeout_next    = cfg_wr_en ? cfg_wr_data : timeout_reg;
        speed_next      = speed_reg;
        mean_next       = mean_reg;
        count_next      = count_reg;
        out_speed_next  = out_speed_reg;
        out_mean_next   = out_mean_reg;
        out_count_next  = out_count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        s_tready        = 1'b0;
        div_req         = '0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    now_next   = s_tdata;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                case (func_reg)
                    FUNC_PULSE: begin
                        last_pulse_next = now_reg;
                        if (elapsed > MIN_PULSE_MS) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = SPEED_NUM;
                            div_req.divisor  = elapsed;
                            state_next       = ST_DIV;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    FUNC_TICK: begin
                        if (elapsed > timeout_reg) begin
                            speed_next = '0;
                        end
                        if (count_reg != {COUNT_WIDTH{1'b1}}) begin
                            count_next = count_reg + 1'b1;
                        end
                        state_next = ST_MEAN;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MEAN: begin
                // count is at least one here
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(diff_mag);
                div_req.divisor  = DIVISOR_W'(count_reg);
                state_next       = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (func_reg == FUNC_PULSE) begin
                        speed_next = quot;
                    end else begin
                        // truncating step, never overshoots the speed
                        mean_next = diff_neg ? (mean_reg - quot) : (mean_reg + quot);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_speed_next = speed_reg;
                    out_mean_next  = mean_reg;
                    out_count_next = REP_COUNT_W'(count_reg);
                    m_tvalid_next  = 1'b1;
                    if (func_reg == FUNC_READ_CLEAR) begin
                        mean_next  = '0;
                        count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_pulse_reg <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            speed_reg      <= '0;
            mean_reg       <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_pulse_reg <= last_pulse_next;
            timeout_reg    <= timeout_next;
            speed_reg      <= speed_next;
            mean_reg       <= mean_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        now_reg       <= now_next;
        out_speed_reg <= out_speed_next;
        out_mean_reg  <= out_mean_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_count_reg, out_mean_reg, out_speed_reg};

    `WSPM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "item accepted while previous still in work")
    `WSPM_ASSERT_NOW(a_div_done_in_div, aclk, aresetn, div_rsp.done, state_reg == ST_DIV, "divider finished outside division state")
    `WSPM_ASSERT_NOW(a_speed_range, aclk, aresetn, 1'b1, speed_reg <= SPEED_MAX && mean_reg <= SPEED_MAX, "speed or mean out of range")
    `WSPM_ASSERT_NOW(a_count_nonzero, aclk, aresetn, state_reg == ST_MEAN, count_reg != '0, "mean step with zero count")

endmodule

[tb/wind_speed_pulse_meter_checker.sv]
`timescale 1ns / 1ps

module wind_speed_pulse_meter_checker
    import wspm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,     // now_ms
    input  logic [FUNC_W-1:0] s_tuser,     // func
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,     // speed_now, speed_mean, mean_count, zero pad
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data, // timeout_ms
    output int                fail_count,
    output int                readings_due
);

    typedef struct packed {
        logic [SPEED_W-1:0]     speed_now;
        logic [SPEED_W-1:0]     speed_mean;
        logic [REP_COUNT_W-1:0] mean_count;
    } reading_t;

    logic [TIME_W-1:0]      last_pulse_ms;
    logic [TIME_W-1:0]      timeout_ms;
    logic [SPEED_W-1:0]     speed_q;
    logic [SPEED_W-1:0]     mean_q;
    logic [COUNT_WIDTH-1:0] count_q;
    reading_t               expected_readings[$];
    int                     mismatch_count = 0;
    int                     queued = 0;

    assign fail_count   = mismatch_count;
    assign readings_due = queued;

    // advances the meter state by one item and returns what the block should report
    function automatic reading_t meter_step(input logic [FUNC_W-1:0] func,
                                            input logic [TIME_W-1:0] now);
        reading_t          r;
        logic [TIME_W-1:0] gap;
        longint            diff;
        gap = now - last_pulse_ms;
        if (func == FUNC_PULSE) begin
            if (gap > MIN_PULSE_MS) begin
                speed_q = SPEED_W'(32'(SPEED_NUM) / gap);
            end
            last_pulse_ms = now;
        end else if (func == FUNC_TICK) begin
            if (gap > timeout_ms) begin
                speed_q = '0;
            end
            if (count_q != '1) begin
                count_q = count_q + 1'b1;
            end
            // signed step, truncated toward zero
            diff   = longint'(speed_q) - longint'(mean_q);
            mean_q = SPEED_W'(longint'(mean_q) + diff / longint'(count_q));
        end
        r.speed_now  = speed_q;
        r.speed_mean = mean_q;
        r.mean_count = REP_COUNT_W'(count_q);
        if (func == FUNC_READ_CLEAR) begin
            mean_q  = '0;
            count_q = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        reading_t want;
        reading_t got;
        if (!aresetn) begin
            last_pulse_ms = '0;
            timeout_ms    = TIMEOUT_RESET;
            speed_q       = '0;
            mean_q        = '0;
            count_q       = '0;
            expected_readings.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.speed_now  = m_tdata[13:0];
                got.speed_mean = m_tdata[27:14];
                got.mean_count = m_tdata[43:28];
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, expected nothing, got %h",
                             $time, m_tdata);
                end else begin
                    want = expected_readings.pop_front();
                    check_field("speed_now", 16'(want.speed_now), 16'(got.speed_now));
                    check_field("speed_mean", 16'(want.speed_mean), 16'(got.speed_mean));
                    check_field("mean_count", want.mean_count, got.mean_count);
                end
            end
            if (cfg_wr_en) begin
                timeout_ms = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(meter_step(s_tuser, s_tdata));
            end
        end
        queued = expected_readings.size();
    end

endmodule

[tb/wind_speed_pulse_meter_core_tb.sv]
`timescale 1ns / 1ps

module wind_speed_pulse_meter_core_tb;
    import wspm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 30;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic [FUNC_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [47:0]       m_tdata;
    logic              cfg_wr_en;
    logic [31:0]       cfg_wr_data;
    int                fail_count;
    int                readings_due;

    bit                idle_on      = 1'b1;
    bit                hold_off_req = 1'b0;
    logic [31:0]       clock_ms;
    logic [31:0]       last_pulse_stamp;
    logic [31:0]       timeout_set;

    wind_speed_pulse_meter_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    wind_speed_pulse_meter_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .readings_due (readings_due)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls per item while idle_on is set, one long hold-off on request
    initial begin : result_sink
        int unsigned wait_cycles;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            wait_cycles = idle_on ? $urandom_range(0, 4) : 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // leaves tvalid high; the next call or the drain wait updates it in the same step
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [31:0] stamp);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= stamp;
        if (func == FUNC_PULSE) begin
            last_pulse_stamp = stamp;
        end
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (readings_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        timeout_set = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_random(input int n_items);
        int unsigned       pick;
        logic [FUNC_W-1:0] func;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                func = FUNC_PULSE;
            end else if (pick < 85) begin
                func = FUNC_TICK;
            end else if (pick < 95) begin
                func = FUNC_READ_CLEAR;
            end else begin
                func = FUNC_UNUSED;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                clock_ms = clock_ms + $urandom_range(0, 5);
            end else if (pick < 70) begin
                clock_ms = clock_ms + $urandom_range(6, 400);
            end else if (pick < 88) begin
                clock_ms = clock_ms + $urandom_range(400, 90000);
            end else if (pick < 95) begin
                // tick landing one below, on, or one past the timeout
                clock_ms = last_pulse_stamp + timeout_set + $urandom_range(0, 2) - 1;
                func     = FUNC_TICK;
            end else begin
                clock_ms = $urandom();
            end
            send_item(func, clock_ms);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_PULSE;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        clock_ms         = '0;
        last_pulse_stamp = '0;
        timeout_set      = TIMEOUT_RESET;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, timeout at its reset value
        send_item(FUNC_UNUSED, 32'd0);
        send_item(FUNC_READ_CLEAR, 32'hFFFF_FFFF);      // clear on an empty mean
        send_item(FUNC_TICK, 32'd0);
        send_item(FUNC_PULSE, 32'd3);                   // too short, speed kept
        send_item(FUNC_PULSE, 32'd8);                   // exactly 5 ms, still ignored
        send_item(FUNC_PULSE, 32'd14);                  // 6 ms, fastest speed
        send_item(FUNC_TICK, 32'd14);
        send_item(FUNC_TICK, 32'd5014);                 // elapsed equals timeout
        send_item(FUNC_TICK, 32'd5015);                 // just past, speed zeroed, mean falls
        send_item(FUNC_READ_CLEAR, 32'd5015);
        send_item(FUNC_PULSE, 32'hFFFF_FFF0);
        send_item(FUNC_PULSE, 32'h0000_0010);           // delta across the wrap
        send_item(FUNC_PULSE, 32'd16 + 32'd84480);      // speed of one lsb
        send_item(FUNC_PULSE, 32'd84496 + 32'd84481);   // rounds down to zero
        send_item(FUNC_PULSE, 32'd168976);              // largest delta
        send_item(FUNC_PULSE, 32'd168982);
        send_item(FUNC_TICK, 32'd168982);
        send_item(FUNC_TICK, 32'd168990);
        send_item(FUNC_TICK, 32'd169000);
        send_item(FUNC_READ_CLEAR, 32'd169000);
        send_item(FUNC_UNUSED, 32'hAAAA_5555);
        send_item(FUNC_TICK, 32'h5555_AAAA);
        send_item(FUNC_READ_CLEAR, 32'h5555_AAAA);
        clock_ms = 32'h5555_AAAA;

        wait_drained();
        write_timeout(32'd0);
        run_random(230);

        wait_drained();
        write_timeout(32'hFFFF_FFFF);
        idle_on = 1'b0;
        run_random(230);

        wait_drained();
        write_timeout($urandom_range(6, 2000));
        idle_on = 1'b1;
        hold_off_req = 1'b1;
        idle_on = 1'b0;
        run_random(20);                                 // back-to-back into the stalled output
        idle_on = 1'b1;
        run_random(100);
        wait_drained();                                 // sender pause until all results are in
        run_random(110);

        wait_drained();
        write_timeout($urandom());
        run_random(200);

        wait_drained();
        write_timeout($urandom_range(0, 400));
        run_random(230);

        wait_drained();
        write_timeout(TIMEOUT_RESET);
        run_random(230);

        wait_drained();
        if (fail_count == 0 && readings_due == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/wspm_pkg.sv
hdl/wspm_div.sv
hdl/wind_speed_pulse_meter_core.sv
tb/wind_speed_pulse_meter_checker.sv
tb/wind_speed_pulse_meter_core_tb.sv
